// ===== sv/mbrt_pkg.sv =====
// shared types, constants and crc helper for the modbus rtu master transaction block
package mbrt_pkg;

	localparam int MAX_FRAME = 32;
	localparam int ADDR_W = $clog2(MAX_FRAME);
	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int APB_ADDR_W = 3;

	localparam logic [7:0] MAX_DATA_LEN = 8'(MAX_FRAME - 4);
	localparam logic [7:0] SLAVE_ADDR = 8'hFE;
	localparam logic [7:0] EXC_BIT = 8'h80;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_LSB = 16'h0001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// register select bit of paddr
	localparam logic REG_TIMEOUT = 1'b0;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_PAYLOAD = 2'd1;
	localparam logic [1:0] REQ_RX = 2'd2;
	localparam logic [1:0] REQ_TICK = 2'd3;

	localparam logic [1:0] KIND_TX = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_BAD_ADDR = 3'd1;
	localparam logic [2:0] STAT_FUNC = 3'd2;
	localparam logic [2:0] STAT_CRC = 3'd3;
	localparam logic [2:0] STAT_EXC = 3'd4;
	localparam logic [2:0] STAT_TIMEOUT = 3'd5;
	localparam logic [2:0] STAT_SIZE = 3'd6;
	localparam logic [2:0] STAT_OVERFLOW = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CRC,
		S_FEED_FUNC,
		S_TX_ADDR,
		S_TX_FUNC,
		S_TX_DATA,
		S_TX_CRC_LO,
		S_TX_CRC_HI,
		S_STATUS,
		S_RD_REQ,
		S_RD_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] fcode;
		logic [7:0] payload_length;
		logic [7:0] response_length;
		logic [7:0] data_byte;
	} req_item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic [2:0] status;
		logic [7:0] exception_code;
		logic       last;
	} rsp_item_t;

	// one bit step of the reflected crc-16/modbus
	function automatic logic [15:0] crc_bit(input logic [15:0] crc);
		logic [15:0] sh;
		sh = crc >> 1;
		if ((crc & CRC_LSB) != 16'h0000) begin
			return sh ^ CRC_POLY;
		end
		return sh;
	endfunction

endpackage

// ===== sv/mbrt_ram.sv =====
// generic single write port ram with registered read
module mbrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/modbus_rtu_master_transaction.sv =====
// modbus rtu master: one request/response transaction with crc-16/modbus
//
// items enter on req (valid/ready) and results leave on rsp (valid/ready).
// a start item sends address 0xFE and the function code; payload items send
// their byte; after the last payload byte the crc goes out low byte first.
// received line bytes are checked for address, function or exception form
// and crc; the block then reports a status, followed on success by the
// response data bytes. tick items advance the timeout count (timeout_ticks,
// written over the apb port, reset value 1000).
// the crc is run one bit per cycle on a single shared crc unit. a start
// item runs the crc over the address, feeds in the function code and runs
// the crc again before the address and function code go out; a payload
// item runs its byte through the crc before the byte goes out; a received
// byte other than the two crc bytes is run through the crc. a successful
// response streams its data bytes out of the receive buffer ram, each one
// read and then output. req_ready is high only while the sequencer is idle.
// a finished result waits in the output register when rsp_ready is low and
// the next item can still be accepted once the sequencer is idle.
// reset clears the sequencer and transaction state and sets timeout_ticks to
// 1000; the receive buffer needs no clearing.
module modbus_rtu_master_transaction
	import mbrt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_item_t             req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_item_t             rsp
);

	state_t state_q, state_d, ret_q, dec_state, dec_ret;

	logic [2:0]       bit_cnt_q;
	logic [15:0]      crc_q, dec_crc;
	logic             busy_q;
	logic [7:0]       func_q, elen_q, prem_q, byte_q;
	logic [CNT_W-1:0] rcount_q;
	logic [15:0]      elapsed_q, elapsed_inc, timeout_q;
	logic             rx_exc_q;
	logic [7:0]       crc_lo_q, b2_q, exc_code_q, rd_left_q;
	logic [2:0]       status_q, dec_status;
	logic [7:0]       dec_code;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q, emit_item;

	logic       fire, size_bad, rx_full, rx_take, emit_req, emit, out_free, rd_more;
	logic       ram_we, ram_re;
	logic [7:0] ram_rdata;
	logic [8:0] idx9, tgt9;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign fire      = req_valid && req_ready;

	assign size_bad = (req.response_length > MAX_DATA_LEN) ||
	                  (req.payload_length > MAX_DATA_LEN);
	assign rx_full  = (rcount_q >= CNT_W'(MAX_FRAME));
	assign rx_take  = busy_q && (prem_q == 8'd0) && !rx_full;
	assign idx9     = 9'(rcount_q);
	assign tgt9     = rx_exc_q ? 9'd5 : ({1'b0, elen_q} + 9'd4);
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign rd_more  = (status_q == STAT_OK) && (elen_q != 8'd0);

	// what an accepted item does
	always_comb begin
		dec_state  = S_IDLE;
		dec_ret    = S_IDLE;
		dec_status = STAT_OK;
		dec_code   = 8'h00;
		dec_crc    = crc_q;
		case (req.req_type)
			REQ_START: begin
				if (size_bad) begin
					dec_state  = S_STATUS;
					dec_status = STAT_SIZE;
				end else begin
					dec_state = S_CRC;
					dec_crc   = CRC_INIT ^ {8'h00, SLAVE_ADDR};
					dec_ret   = S_FEED_FUNC;
				end
			end
			REQ_PAYLOAD: begin
				if (busy_q && prem_q != 8'd0) begin
					dec_state = S_CRC;
					dec_crc   = crc_q ^ {8'h00, req.data_byte};
					dec_ret   = S_TX_DATA;
				end
			end
			REQ_RX: begin
				if (busy_q && prem_q == 8'd0) begin
					if (rx_full) begin
						dec_state  = S_STATUS;
						dec_status = STAT_OVERFLOW;
					end else if (idx9 == 9'd0) begin
						if (req.data_byte != SLAVE_ADDR) begin
							dec_state  = S_STATUS;
							dec_status = STAT_BAD_ADDR;
						end else begin
							dec_state = S_CRC;
							dec_crc   = crc_q ^ {8'h00, req.data_byte};
						end
					end else if (idx9 == 9'd1) begin
						if (req.data_byte != func_q && req.data_byte != (func_q | EXC_BIT)) begin
							dec_state  = S_STATUS;
							dec_status = STAT_FUNC;
						end else begin
							dec_state = S_CRC;
							dec_crc   = crc_q ^ {8'h00, req.data_byte};
						end
					end else if (idx9 < tgt9 - 9'd2) begin
						dec_state = S_CRC;
						dec_crc   = crc_q ^ {8'h00, req.data_byte};
					end else if (idx9 == tgt9 - 9'd2) begin
						dec_state = S_IDLE;
					end else if ({req.data_byte, crc_lo_q} != crc_q) begin
						dec_state  = S_STATUS;
						dec_status = STAT_CRC;
					end else if (rx_exc_q) begin
						dec_state  = S_STATUS;
						dec_status = STAT_EXC;
						dec_code   = b2_q;
					end else begin
						dec_state  = S_STATUS;
						dec_status = STAT_OK;
					end
				end
			end
			default: begin
				if (busy_q && elapsed_inc > timeout_q) begin
					dec_state  = S_STATUS;
					dec_status = STAT_TIMEOUT;
				end
			end
		endcase
	end

	assign out_free = !rsp_valid_q || rsp_ready;
	assign emit     = emit_req && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (req_valid) state_d = dec_state;
			S_CRC:       if (bit_cnt_q == 3'd7) state_d = ret_q;
			S_FEED_FUNC: state_d = S_CRC;
			S_TX_ADDR:   if (emit) state_d = S_TX_FUNC;
			S_TX_FUNC,
			S_TX_DATA:   if (emit) state_d = (prem_q == 8'd0) ? S_TX_CRC_LO : S_IDLE;
			S_TX_CRC_LO: if (emit) state_d = S_TX_CRC_HI;
			S_TX_CRC_HI: if (emit) state_d = S_IDLE;
			S_STATUS:    if (emit) state_d = rd_more ? S_RD_REQ : S_IDLE;
			S_RD_REQ:    state_d = S_RD_EMIT;
			S_RD_EMIT:   if (emit) state_d = (rd_left_q == 8'd1) ? S_IDLE : S_RD_REQ;
			default:     state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit_req  = 1'b0;
		emit_item = '0;
		ram_re    = 1'b0;
		unique case (state_q)
			S_TX_ADDR: begin
				emit_req           = 1'b1;
				emit_item.out_kind = KIND_TX;
				emit_item.out_byte = SLAVE_ADDR;
			end
			S_TX_FUNC: begin
				emit_req           = 1'b1;
				emit_item.out_kind = KIND_TX;
				emit_item.out_byte = func_q;
				emit_item.last     = (prem_q != 8'd0);
			end
			S_TX_DATA: begin
				emit_req           = 1'b1;
				emit_item.out_kind = KIND_TX;
				emit_item.out_byte = byte_q;
				emit_item.last     = (prem_q != 8'd0);
			end
			S_TX_CRC_LO: begin
				emit_req           = 1'b1;
				emit_item.out_kind = KIND_TX;
				emit_item.out_byte = crc_q[7:0];
			end
			S_TX_CRC_HI: begin
				emit_req           = 1'b1;
				emit_item.out_kind = KIND_TX;
				emit_item.out_byte = crc_q[15:8];
				emit_item.last     = 1'b1;
			end
			S_STATUS: begin
				emit_req                 = 1'b1;
				emit_item.out_kind       = KIND_STATUS;
				emit_item.status         = status_q;
				emit_item.exception_code = exc_code_q;
				emit_item.last           = !rd_more;
			end
			S_RD_REQ: ram_re = 1'b1;
			S_RD_EMIT: begin
				emit_req           = 1'b1;
				emit_item.out_kind = KIND_DATA;
				emit_item.out_byte = ram_rdata;
				emit_item.last     = (rd_left_q == 8'd1);
			end
			default: emit_req = 1'b0;
		endcase
	end

	assign ram_we = fire && (req.req_type == REQ_RX) && rx_take;

	mbrt_ram #(
		.WIDTH(8),
		.DEPTH(MAX_FRAME)
	) u_rx_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(rcount_q[ADDR_W-1:0]),
		.wdata(req.data_byte),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// transaction state and the shared crc unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q      <= S_IDLE;
			bit_cnt_q  <= 3'd0;
			crc_q      <= CRC_INIT;
			busy_q     <= 1'b0;
			func_q     <= 8'h00;
			elen_q     <= 8'h00;
			prem_q     <= 8'h00;
			byte_q     <= 8'h00;
			rcount_q   <= '0;
			elapsed_q  <= 16'h0000;
			rx_exc_q   <= 1'b0;
			crc_lo_q   <= 8'h00;
			b2_q       <= 8'h00;
			status_q   <= STAT_OK;
			exc_code_q <= 8'h00;
			rd_ptr_q   <= '0;
			rd_left_q  <= 8'h00;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						byte_q    <= req.data_byte;
						crc_q     <= dec_crc;
						ret_q     <= dec_ret;
						bit_cnt_q <= 3'd0;
						if (dec_state == S_STATUS) begin
							busy_q     <= 1'b0;
							status_q   <= dec_status;
							exc_code_q <= dec_code;
							rd_ptr_q   <= ADDR_W'(2);
							rd_left_q  <= elen_q;
						end
						case (req.req_type)
							REQ_START: begin
								if (!size_bad) begin
									busy_q    <= 1'b1;
									func_q    <= req.fcode;
									elen_q    <= req.response_length;
									prem_q    <= req.payload_length;
									rcount_q  <= '0;
									elapsed_q <= 16'h0000;
								end
							end
							REQ_PAYLOAD: begin
								if (busy_q && prem_q != 8'd0) begin
									prem_q <= prem_q - 8'd1;
								end
							end
							REQ_RX: begin
								if (rx_take) begin
									rcount_q <= rcount_q + CNT_W'(1);
									if (idx9 == 9'd1) begin
										rx_exc_q <= (req.data_byte == (func_q | EXC_BIT));
									end
									if (idx9 == 9'd2) begin
										b2_q <= req.data_byte;
									end
									if (idx9 == tgt9 - 9'd2) begin
										crc_lo_q <= req.data_byte;
									end
								end
							end
							default: begin
								if (busy_q) begin
									elapsed_q <= elapsed_inc;
								end
							end
						endcase
					end
				end
				S_CRC: begin
					crc_q     <= crc_bit(crc_q);
					bit_cnt_q <= bit_cnt_q + 3'd1;
				end
				S_FEED_FUNC: begin
					crc_q     <= crc_q ^ {8'h00, func_q};
					ret_q     <= S_TX_ADDR;
					bit_cnt_q <= 3'd0;
				end
				S_TX_CRC_HI: begin
					// receiver crc starts fresh once the request is out
					if (emit) begin
						crc_q <= CRC_INIT;
					end
				end
				S_RD_EMIT: begin
					if (emit) begin
						rd_ptr_q  <= rd_ptr_q + ADDR_W'(1);
						rd_left_q <= rd_left_q - 8'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_status_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STATUS |-> !busy_q)
		else $error("status reported while transaction still open");

	a_rd_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_EMIT |-> rd_left_q != 8'd0)
		else $error("data readout with nothing left");

	a_rcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= CNT_W'(MAX_FRAME))
		else $error("receive count beyond frame size");

	a_crc_eight_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CRC && bit_cnt_q == 3'd7 |=> state_q != S_CRC)
		else $error("crc unit ran past one byte");

	a_tx_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TX_DATA |-> busy_q)
		else $error("payload byte sent outside a transaction");

endmodule
